// ===== design/tgf_pkg.sv =====
package tgf_pkg;

  // command codes
  localparam logic [1:0] CMD_DRAW  = 2'd0;
  localparam logic [1:0] CMD_CLEAR = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  // glyph width in columns; the spacer column follows the last one
  localparam logic [2:0] GLYPH_COLS = 3'd5;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] column;
    logic [7:0] page_row;
    logic [7:0] char_code;
  } tgf_in_t;

  typedef struct packed {
    logic [7:0] read_byte;
    logic       accepted;
  } tgf_out_t;

  // glyph rom, column 0 in the low byte; codes without a glyph are blank
  function automatic logic [39:0] glyph_cols(input logic [7:0] code);
    logic [39:0] g;
    case (code)
      8'h30:   g = 40'h3E_45_49_51_3E;
      8'h31:   g = 40'h00_40_7F_42_00;
      8'h32:   g = 40'h46_49_51_61_42;
      8'h33:   g = 40'h31_4B_45_41_21;
      8'h34:   g = 40'h10_7F_12_14_18;
      8'h35:   g = 40'h39_45_45_45_27;
      8'h36:   g = 40'h30_49_49_4A_3C;
      8'h37:   g = 40'h03_05_09_71_01;
      8'h38:   g = 40'h36_49_49_49_36;
      8'h39:   g = 40'h1E_29_49_49_06;
      8'h3A:   g = 40'h00_00_36_36_00;
      8'h2E:   g = 40'h00_00_60_60_00;
      8'h41:   g = 40'h7E_11_11_11_7E;
      8'h44:   g = 40'h1C_22_41_41_7F;
      8'h46:   g = 40'h01_09_09_09_7F;
      8'h4D:   g = 40'h7F_02_0C_02_7F;
      8'h53:   g = 40'h31_49_49_49_46;
      8'h54:   g = 40'h01_01_7F_01_01;
      8'h57:   g = 40'h7F_20_18_20_7F;
      8'h61:   g = 40'h78_54_54_54_20;
      8'h64:   g = 40'h7F_48_44_44_38;
      8'h65:   g = 40'h18_54_54_54_38;
      8'h68:   g = 40'h78_04_04_08_7F;
      8'h69:   g = 40'h00_40_7D_44_00;
      8'h6E:   g = 40'h78_04_04_08_7C;
      8'h6F:   g = 40'h38_44_44_44_38;
      8'h72:   g = 40'h08_04_04_08_7C;
      8'h74:   g = 40'h20_40_44_3F_04;
      8'h75:   g = 40'h7C_20_40_40_3C;
      default: g = 40'h00_00_00_00_00;
    endcase
    return g;
  endfunction

endpackage

// ===== design/tgf_ram.sv =====
module tgf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/text_glyph_framebuffer.sv =====
// channel  direction  handshake                  beat
// in       input      in_valid_i / in_ready_o    tgf_in_t  (command, column, page_row, char_code)
// out      output     out_valid_o / out_ready_i  tgf_out_t (read_byte, accepted)
//
// a draw makes one store write per glyph column plus the spacer, single port
// a read goes through a registered store read, in range or not
// an ignored draw or the unused command code gets its beat without a store access
// a clear is accepted, then one entry zeroed per cycle through the whole store
// after reset the same clearing pass runs with in_ready_o low
// a stalled output holds its beat; the next command is taken while it waits
module text_glyph_framebuffer
  import tgf_pkg::*;
#(
  parameter int COLUMNS = 128,
  parameter int PAGES   = 8
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  tgf_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output tgf_out_t out_data_o
);

  localparam int DEPTH = COLUMNS * PAGES;
  localparam int AW    = $clog2(DEPTH);
  localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_DRAW  = 3'd1;
  localparam logic [2:0] ST_READ  = 3'd2;
  localparam logic [2:0] ST_CLEAR = 3'd3;
  localparam logic [2:0] ST_WAIT  = 3'd4;

  logic [2:0]    state_q, state_d;
  logic          init_q, init_d;       // clearing pass after reset, no beat out
  logic [AW-1:0] clr_q, clr_d;
  logic [AW-1:0] base_q, base_d;       // page start address
  logic [8:0]    x_q, x_d;             // current draw column, may run past the edge
  logic [2:0]    cnt_q, cnt_d;
  logic [39:0]   glyph_q, glyph_d;     // remaining glyph columns, zeros shift in for spacer
  logic          rd_ok_q, rd_ok_d;
  tgf_out_t      res_q, res_d;         // result parked while output is full
  logic          out_valid_q, out_valid_d;
  tgf_out_t      out_data_q, out_data_d;

  logic          ram_we;
  logic [AW-1:0] ram_addr;
  logic [7:0]    ram_wdata;
  logic [7:0]    ram_rdata;

  logic          pos_ok;
  logic [AW-1:0] in_base;
  logic [39:0]   in_glyph;
  logic          emit;
  tgf_out_t      emit_data;
  logic          slot_free;

  tgf_ram #(
    .WIDTH(8),
    .DEPTH(DEPTH)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .addr_i (ram_addr),
    .wdata_i(ram_wdata),
    .rdata_o(ram_rdata)
  );

  assign pos_ok   = (32'(in_data_i.column) < COLUMNS) && (32'(in_data_i.page_row) < PAGES);
  assign in_base  = AW'(32'(in_data_i.page_row) * COLUMNS);
  assign in_glyph = glyph_cols(in_data_i.char_code);
  assign slot_free = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d     = state_q;
    init_d      = init_q;
    clr_d       = clr_q;
    base_d      = base_q;
    x_d         = x_q;
    cnt_d       = cnt_q;
    glyph_d     = glyph_q;
    rd_ok_d     = rd_ok_q;
    res_d       = res_q;
    ram_we      = 1'b0;
    ram_addr    = base_q + AW'(x_q);
    ram_wdata   = glyph_q[7:0];
    emit        = 1'b0;
    emit_data   = '0;

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          case (in_data_i.command)
            CMD_DRAW: begin
              if (pos_ok) begin
                // first glyph column goes out in the accept cycle
                ram_we    = 1'b1;
                ram_addr  = in_base + AW'(in_data_i.column);
                ram_wdata = in_glyph[7:0];
                glyph_d   = in_glyph >> 8;
                x_d       = {1'b0, in_data_i.column} + 9'd1;
                base_d    = in_base;
                cnt_d     = 3'd1;
                state_d   = ST_DRAW;
              end else begin
                emit = 1'b1;
              end
            end
            CMD_CLEAR: begin
              clr_d   = '0;
              state_d = ST_CLEAR;
            end
            CMD_READ: begin
              ram_addr = in_base + AW'(in_data_i.column);
              rd_ok_d  = pos_ok;
              state_d  = ST_READ;
            end
            default: begin
              emit = 1'b1;
            end
          endcase
        end
      end
      ST_DRAW: begin
        // clip columns past the right edge
        ram_we  = (32'(x_q) < COLUMNS);
        glyph_d = glyph_q >> 8;
        x_d     = x_q + 9'd1;
        cnt_d   = cnt_q + 3'd1;
        if (cnt_q == GLYPH_COLS) begin
          emit               = 1'b1;
          emit_data.accepted = 1'b1;
        end
      end
      ST_READ: begin
        emit                = 1'b1;
        emit_data.read_byte = rd_ok_q ? ram_rdata : 8'h00;
        emit_data.accepted  = rd_ok_q;
      end
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_addr  = clr_q;
        ram_wdata = 8'h00;
        clr_d     = clr_q + AW'(1);
        if (clr_q == LAST_ADDR) begin
          if (init_q) begin
            init_d  = 1'b0;
            state_d = ST_IDLE;
          end else begin
            emit               = 1'b1;
            emit_data.accepted = 1'b1;
          end
        end
      end
      ST_WAIT: begin
        emit      = 1'b1;
        emit_data = res_q;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (emit) begin
      if (slot_free) begin
        state_d = ST_IDLE;
      end else begin
        res_d   = emit_data;
        state_d = ST_WAIT;
      end
    end
  end

  // output register
  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    out_data_d  = out_data_q;
    if (emit && slot_free) begin
      out_valid_d = 1'b1;
      out_data_d  = emit_data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      init_q      <= 1'b1;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      init_q      <= init_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    base_q     <= base_d;
    x_q        <= x_d;
    cnt_q      <= cnt_d;
    glyph_q    <= glyph_d;
    rd_ok_q    <= rd_ok_d;
    res_q      <= res_d;
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// ===== tb/text_glyph_framebuffer_tb.sv =====
module text_glyph_framebuffer_tb;
  import tgf_pkg::*;

  localparam int COLS         = 128;
  localparam int PGS          = 8;
  localparam int RANDOM_ITEMS = 600;
  // slowest run: the clear after reset, the full clear on each clear beat,
  // draws, long sender gaps and long receiver stalls; taken several times over
  localparam int CYCLE_LIMIT  = 400000;
  // cycles left after the last beat for a stray result to show up
  localparam int HOLD_OFF     = 24;

  // command code with no action; the package names only the three used ones
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  logic     clk_i       = 1'b0;
  logic     rst_ni      = 1'b0;
  logic     in_valid_i  = 1'b0;
  logic     in_ready_o;
  tgf_in_t  in_data_i   = '0;
  logic     out_valid_o;
  logic     out_ready_i = 1'b0;
  tgf_out_t out_data_o;

  text_glyph_framebuffer #(
    .COLUMNS (COLS),
    .PAGES   (PGS)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // predictor state: page-organized copy of the frame store
  // ---------------------------------------------------------------------------
  logic [7:0] pixel_pages [COLS*PGS];

  tgf_in_t  pending_cmd_q [$];    // beats waiting to be driven
  tgf_out_t expected_out_q [$];   // predicted result beats, oldest first

  int beats_queued  = 0;
  int beats_taken   = 0;
  int mismatches    = 0;
  int cycle_count   = 0;

  // glyph columns, column 0 in the top byte; anything without a glyph is blank
  function automatic logic [39:0] glyph_bytes(input logic [7:0] code);
    case (code)
      8'h30:   return 40'h3E_51_49_45_3E;  // 0
      8'h31:   return 40'h00_42_7F_40_00;
      8'h32:   return 40'h42_61_51_49_46;
      8'h33:   return 40'h21_41_45_4B_31;
      8'h34:   return 40'h18_14_12_7F_10;
      8'h35:   return 40'h27_45_45_45_39;
      8'h36:   return 40'h3C_4A_49_49_30;
      8'h37:   return 40'h01_71_09_05_03;
      8'h38:   return 40'h36_49_49_49_36;
      8'h39:   return 40'h06_49_49_29_1E;  // 9
      8'h3A:   return 40'h00_36_36_00_00;  // colon
      8'h2E:   return 40'h00_60_60_00_00;  // period
      8'h41:   return 40'h7E_11_11_11_7E;  // A
      8'h44:   return 40'h7F_41_41_22_1C;
      8'h46:   return 40'h7F_09_09_09_01;
      8'h4D:   return 40'h7F_02_0C_02_7F;
      8'h53:   return 40'h46_49_49_49_31;
      8'h54:   return 40'h01_01_7F_01_01;
      8'h57:   return 40'h7F_20_18_20_7F;  // W
      8'h61:   return 40'h20_54_54_54_78;  // a
      8'h64:   return 40'h38_44_44_48_7F;
      8'h65:   return 40'h38_54_54_54_18;
      8'h68:   return 40'h7F_08_04_04_78;
      8'h69:   return 40'h00_44_7D_40_00;
      8'h6E:   return 40'h7C_08_04_04_78;
      8'h6F:   return 40'h38_44_44_44_38;
      8'h72:   return 40'h7C_08_04_04_08;
      8'h74:   return 40'h04_3F_44_40_20;
      8'h75:   return 40'h3C_40_40_20_7C;  // u
      default: return 40'h00_00_00_00_00;  // space and every unknown code
    endcase
  endfunction

  // applies one command to the store copy and returns the beat it should produce
  task automatic render_predict(input tgf_in_t cmd, output tgf_out_t res);
    int         col;
    int         page;
    int         x;
    logic [39:0] glyph;
    col   = int'(cmd.column);
    page  = int'(cmd.page_row);
    res   = '0;
    glyph = glyph_bytes(cmd.char_code);
    case (cmd.command)
      CMD_DRAW: begin
        if (col < COLS && page < PGS) begin
          // five glyph columns then the spacer, clipped at the right edge
          for (int i = 0; i <= 5; i++) begin
            x = col + i;
            if (x < COLS) begin
              pixel_pages[page*COLS + x] = (i < 5) ? glyph[39-8*i -: 8] : 8'h00;
            end
          end
          res.accepted = 1'b1;
        end
      end
      CMD_CLEAR: begin
        for (int k = 0; k < COLS*PGS; k++) pixel_pages[k] = 8'h00;
        res.accepted = 1'b1;
      end
      CMD_READ: begin
        if (col < COLS && page < PGS) begin
          res.read_byte = pixel_pages[page*COLS + col];
          res.accepted  = 1'b1;
        end
      end
      default: ;  // unused code: nothing happens, nothing accepted
    endcase
  endtask

  task automatic flag_mismatch(input string what, input int got, input int want);
    $display("mismatch at cycle %0d: %s got %0h want %0h", cycle_count, what, got, want);
    mismatches++;
  endtask

  // idle lengths: mostly none or short, now and then long; none at all in calm stretches
  function automatic int idle_len(input bit calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // ---------------------------------------------------------------------------
  // driver: feeds pending beats, holds each one until it is taken
  // ---------------------------------------------------------------------------
  int send_gap  = 0;
  bit send_calm = 1'b0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i  <= '0;
    end else if (!in_valid_i || in_ready_o) begin
      // either idle or the current beat is taken at this edge
      if (in_valid_i) begin
        send_gap = idle_len(send_calm);
        if ($urandom_range(0, 39) == 0) send_calm = !send_calm;
      end
      if (send_gap > 0) begin
        send_gap--;
        in_valid_i <= 1'b0;
      end else if (pending_cmd_q.size() > 0) begin
        in_data_i  <= pending_cmd_q.pop_front();
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: predicts on every taken input beat, checks every taken output beat,
  // and stalls the output side at random
  // ---------------------------------------------------------------------------
  int stall_left = 0;
  bit recv_calm  = 1'b0;

  always @(posedge clk_i or negedge rst_ni) begin
    tgf_out_t predicted;
    tgf_out_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      // predict first; the result of a beat never shows up on the edge that takes it
      if (in_valid_i && in_ready_o) begin
        render_predict(in_data_i, predicted);
        expected_out_q.push_back(predicted);
        beats_taken++;
      end
      if (out_valid_o && out_ready_i) begin
        if (expected_out_q.size() == 0) begin
          flag_mismatch("result with nothing pending, read_byte", out_data_o.read_byte, 0);
        end else begin
          want = expected_out_q.pop_front();
          if (out_data_o.read_byte !== want.read_byte)
            flag_mismatch("read_byte", out_data_o.read_byte, want.read_byte);
          if (out_data_o.accepted !== want.accepted)
            flag_mismatch("accepted", out_data_o.accepted, want.accepted);
        end
        stall_left = idle_len(recv_calm);
        if ($urandom_range(0, 39) == 0) recv_calm = !recv_calm;
      end else if (stall_left == 0 && $urandom_range(0, 24) == 0) begin
        // occasional stall while a beat is being worked on
        stall_left = idle_len(recv_calm);
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, expected_out_q.size());
      $display("[text_glyph_framebuffer] ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  task automatic queue_beat(input logic [1:0] cmd, input int col, input int page,
                            input int code);
    tgf_in_t b;
    b.command   = cmd;
    b.column    = col[7:0];
    b.page_row  = page[7:0];
    b.char_code = code[7:0];
    pending_cmd_q.push_back(b);
    beats_queued++;
  endtask

  // blocks until every queued beat is taken and every result has arrived
  task automatic wait_drained();
    while (beats_taken != beats_queued || expected_out_q.size() != 0) @(negedge clk_i);
  endtask

  function automatic logic [7:0] known_code();
    string s;
    s = "0123456789:. ADFMSTWadehinortu";
    return s[$urandom_range(0, s.len() - 1)];
  endfunction

  int recent_col  = 0;
  int recent_page = 0;

  // random traffic: mostly draws followed by reads around what was drawn,
  // plus out-of-range noise, the unused code and the odd clear
  task automatic queue_random(input int count);
    int r;
    int s;
    int col;
    int page;
    int code;
    for (int n = 0; n < count; n++) begin
      r    = $urandom_range(0, 99);
      col  = $urandom_range(0, 255);
      page = $urandom_range(0, 255);
      code = $urandom_range(0, 255);
      if (r < 50) begin
        if ($urandom_range(0, 99) < 85) begin
          col = ($urandom_range(0, 4) == 0) ? $urandom_range(COLS - 6, COLS - 1)
                                            : $urandom_range(0, COLS - 1);
        end
        if ($urandom_range(0, 99) < 85) page = $urandom_range(0, PGS - 1);
        if ($urandom_range(0, 99) < 75) code = known_code();
        if (col < COLS && page < PGS) begin
          recent_col  = col;
          recent_page = page;
        end
        queue_beat(CMD_DRAW, col, page, code);
      end else if (r < 90) begin
        s = $urandom_range(0, 99);
        if (s < 65) begin
          col  = recent_col + $urandom_range(0, 5);
          if (col >= COLS) col = COLS - 1;
          page = recent_page;
        end else if (s < 90) begin
          col  = $urandom_range(0, COLS - 1);
          page = $urandom_range(0, PGS - 1);
        end
        queue_beat(CMD_READ, col, page, code);
      end else if (r < 98) begin
        queue_beat(CMD_UNUSED, col, page, code);
      end else begin
        queue_beat(CMD_CLEAR, col, page, code);
      end
    end
  endtask

  initial begin
    for (int k = 0; k < COLS*PGS; k++) pixel_pages[k] = 8'h00;

    // directed: store starts blank after reset
    queue_beat(CMD_READ, 0, 0, 8'hFF);
    // plain draw and read back, spacer included
    queue_beat(CMD_DRAW, 0, 0, 8'h30);
    queue_beat(CMD_READ, 0, 0, 8'h00);
    queue_beat(CMD_READ, 4, 0, 8'h00);
    queue_beat(CMD_READ, 5, 0, 8'h00);
    // draw near the right edge gets clipped but is still accepted
    queue_beat(CMD_DRAW, 125, 7, 8'h41);
    queue_beat(CMD_READ, 127, 7, 8'h00);
    // unknown codes draw blank over an existing glyph
    queue_beat(CMD_DRAW, 10, 3, 8'h4D);
    queue_beat(CMD_DRAW, 10, 3, 8'hFF);
    queue_beat(CMD_READ, 12, 3, 8'h00);
    queue_beat(CMD_DRAW, 20, 1, 8'h00);
    // draws outside the store are ignored
    queue_beat(CMD_DRAW, 128, 0, 8'h38);
    queue_beat(CMD_DRAW, 255, 255, 8'h38);
    queue_beat(CMD_DRAW, 0, 8, 8'h38);
    // reads outside the store are ignored
    queue_beat(CMD_READ, 128, 0, 8'h00);
    queue_beat(CMD_READ, 0, 255, 8'h00);
    queue_beat(CMD_READ, 255, 8, 8'h00);
    // unused command code with every field at its top value
    queue_beat(CMD_UNUSED, 255, 255, 255);
    // clear ignores its fields, then everything reads back blank
    queue_beat(CMD_CLEAR, 127, 7, 8'h41);
    queue_beat(CMD_READ, 127, 7, 8'h00);
    queue_beat(CMD_READ, 0, 0, 8'h00);
    // single column at the very last position
    queue_beat(CMD_DRAW, 127, 7, 8'h38);
    queue_beat(CMD_READ, 127, 7, 8'h00);

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    wait_drained();
    // random part in two halves; the sender sits idle until all results are in
    queue_random(RANDOM_ITEMS / 2);
    wait_drained();
    queue_random(RANDOM_ITEMS - RANDOM_ITEMS / 2);
    wait_drained();

    // any stray result in this window is caught by the monitor
    repeat (HOLD_OFF) @(negedge clk_i);
    if (expected_out_q.size() != 0) begin
      flag_mismatch("results left over, count", expected_out_q.size(), 0);
    end

    if (mismatches == 0) begin
      $display("[text_glyph_framebuffer] OK");
    end else begin
      $display("[text_glyph_framebuffer] ERROR");
    end
    $finish;
  end

endmodule
